>>> rtl/core/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared payload types, widths and status codes.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W = 32;
    localparam int THR_W  = 32;
    localparam int NUM_W  = COEF_W + 2;
    localparam int DEN_W  = COEF_W + 1;
    localparam int RAD_W  = 2 * COEF_W + 2;
    localparam int SQRT_W = RAD_W / 2;

    localparam logic [1:0] ST_TWO    = 2'd0;
    localparam logic [1:0] ST_DOUBLE = 2'd1;
    localparam logic [1:0] ST_LINEAR = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } t_coef_in;

    typedef struct packed {
        logic signed [COEF_W-1:0] root_one;
        logic signed [COEF_W-1:0] root_two;
        logic [1:0]               solve_status;
        logic                     overflow;
    } t_root_out;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
        logic                    neg;
        logic [RAD_W-1:0]        rad;
    } t_job;

endpackage

>>> rtl/core/qrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver front end
// Forms b*b and a*c, then the discriminant, and classifies each word.
// ----------------------------------------------------------------------------
module qrs_front
    import qrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_coef_in         i_coef,
    input  logic [THR_W-1:0] i_threshold,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output t_job             o_job
);

    localparam int PROD_W = 2 * COEF_W;
    localparam int DS_W   = PROD_W + 3;

    logic                      w_en;
    logic                      r1_valid;
    logic signed [PROD_W-1:0]  r1_bb;
    logic signed [PROD_W-1:0]  r1_ac;
    logic signed [COEF_W-1:0]  r1_a;
    logic signed [COEF_W-1:0]  r1_b;
    logic signed [COEF_W-1:0]  r1_c;
    logic                      r2_valid;
    t_job                      r2_job;
    t_job                      n2_job;
    logic signed [DS_W-1:0]    w_disc;
    logic [COEF_W:0]           w_a_ext;
    logic [COEF_W:0]           w_b_ext;
    logic [COEF_W:0]           w_a_mag;
    logic [COEF_W:0]           w_b_mag;
    logic signed [NUM_W-1:0]   w_neg_b;
    logic signed [NUM_W-1:0]   w_neg_c;

    assign w_en        = !r2_valid || i_job_ready;
    assign o_ready     = w_en;
    assign o_job_valid = r2_valid;
    assign o_job       = r2_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_bb  <= $signed(i_coef.coef_b) * $signed(i_coef.coef_b);
            r1_ac  <= $signed(i_coef.coef_a) * $signed(i_coef.coef_c);
            r1_a   <= i_coef.coef_a;
            r1_b   <= i_coef.coef_b;
            r1_c   <= i_coef.coef_c;
            r2_job <= n2_job;
        end
    end

    always_comb begin
        w_disc  = $signed({{3{r1_bb[PROD_W-1]}}, r1_bb})
                - $signed({r1_ac[PROD_W-1], r1_ac, 2'b00});
        w_a_ext = {r1_a[COEF_W-1], r1_a};
        w_b_ext = {r1_b[COEF_W-1], r1_b};
        w_a_mag = r1_a[COEF_W-1] ? (~w_a_ext + 1'b1) : w_a_ext;
        w_b_mag = r1_b[COEF_W-1] ? (~w_b_ext + 1'b1) : w_b_ext;
        w_neg_b = -$signed({{2{r1_b[COEF_W-1]}}, r1_b});
        w_neg_c = -$signed({{2{r1_c[COEF_W-1]}}, r1_c});

        n2_job        = '0;
        n2_job.status = ST_NONE;
        n2_job.den    = DEN_W'(1);
        if (r1_a == '0) begin
            if (r1_b != '0) begin
                n2_job.status = ST_LINEAR;
                n2_job.num    = w_neg_c;
                n2_job.den    = w_b_mag;
                n2_job.neg    = r1_b[COEF_W-1];
            end
        end else if (!w_disc[DS_W-1]) begin
            n2_job.num = w_neg_b;
            n2_job.den = {w_a_mag[COEF_W-1:0], 1'b0};
            n2_job.neg = r1_a[COEF_W-1];
            if (w_disc[RAD_W-1:0] >= {{(RAD_W-THR_W){1'b0}}, i_threshold}) begin
                n2_job.status = ST_TWO;
                n2_job.rad    = w_disc[RAD_W-1:0];
            end else begin
                n2_job.status = ST_DOUBLE;
            end
        end
    end

endmodule

>>> rtl/core/qrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver job queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module qrs_queue
    import qrs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

>>> rtl/core/qrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver back end
// Pipelined square root, two pipelined dividers and saturation.
// ----------------------------------------------------------------------------
module qrs_back
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    output logic      o_job_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  logic      i_ready,
    output t_root_out o_root
);

    localparam int SQ_N  = SQRT_W;
    localparam int REM_W = SQRT_W + 1;
    localparam int MAG_W = NUM_W - 1;
    localparam int DV_W  = MAG_W + FRAC_BITS;

    logic w_en;
    assign w_en        = !o_valid || i_ready;
    assign o_job_ready = w_en;

    // Square root pipeline, two radicand bits per stage.
    logic              s_v    [SQ_N+1];
    t_job              s_job  [SQ_N+1];
    logic [REM_W-1:0]  s_rem  [SQ_N+1];
    logic [SQRT_W-1:0] s_root [SQ_N+1];

    assign s_v[0]    = i_job_valid;
    assign s_job[0]  = i_job;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        logic              r_v;
        t_job              r_job;
        logic [REM_W-1:0]  r_rem;
        logic [SQRT_W-1:0] r_root;
        logic [REM_W+1:0]  w_cur;
        logic [REM_W+1:0]  w_trial;
        logic [REM_W+1:0]  w_diff;
        logic              w_ge;

        always_comb begin
            w_cur   = {s_rem[k], s_job[k].rad[RAD_W-1-2*k -: 2]};
            w_trial = {1'b0, s_root[k], 2'b01};
            w_diff  = w_cur - w_trial;
            w_ge    = (w_cur >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_en) begin
                r_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_job  <= s_job[k];
                r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_cur[REM_W-1:0];
                r_root <= {s_root[k][SQRT_W-2:0], w_ge};
            end
        end

        assign s_v[k+1]    = r_v;
        assign s_job[k+1]  = r_job;
        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
    end

    // Numerators -b + s and -b - s in sign and magnitude.
    logic                    r_p_v;
    logic [1:0]              r_p_status;
    logic [DEN_W-1:0]        r_p_den;
    logic                    r_p_neg1;
    logic                    r_p_neg2;
    logic [MAG_W-1:0]        r_p_mag1;
    logic [MAG_W-1:0]        r_p_mag2;
    logic signed [NUM_W-1:0] w_sq;
    logic signed [NUM_W-1:0] w_n1;
    logic signed [NUM_W-1:0] w_n2;

    always_comb begin
        w_sq = $signed({{(NUM_W-SQRT_W){1'b0}}, s_root[SQ_N]});
        w_n1 = s_job[SQ_N].num + w_sq;
        w_n2 = s_job[SQ_N].num - w_sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (w_en) begin
            r_p_v <= s_v[SQ_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_status <= s_job[SQ_N].status;
            r_p_den    <= s_job[SQ_N].den;
            r_p_neg1   <= w_n1[NUM_W-1] ^ s_job[SQ_N].neg;
            r_p_neg2   <= w_n2[NUM_W-1] ^ s_job[SQ_N].neg;
            r_p_mag1   <= w_n1[NUM_W-1] ? MAG_W'(-w_n1) : MAG_W'(w_n1);
            r_p_mag2   <= w_n2[NUM_W-1] ? MAG_W'(-w_n2) : MAG_W'(w_n2);
        end
    end

    // Restoring divider pipeline, one quotient bit per stage, two lanes.
    logic             d_v      [DV_W+1];
    logic [1:0]       d_status [DV_W+1];
    logic [DEN_W-1:0] d_den    [DV_W+1];
    logic             d_neg1   [DV_W+1];
    logic             d_neg2   [DV_W+1];
    logic [DV_W-1:0]  d_dvd1   [DV_W+1];
    logic [DV_W-1:0]  d_dvd2   [DV_W+1];
    logic [DEN_W-1:0] d_rem1   [DV_W+1];
    logic [DEN_W-1:0] d_rem2   [DV_W+1];
    logic [DV_W-1:0]  d_q1     [DV_W+1];
    logic [DV_W-1:0]  d_q2     [DV_W+1];

    assign d_v[0]      = r_p_v;
    assign d_status[0] = r_p_status;
    assign d_den[0]    = r_p_den;
    assign d_neg1[0]   = r_p_neg1;
    assign d_neg2[0]   = r_p_neg2;
    assign d_dvd1[0]   = {r_p_mag1, {FRAC_BITS{1'b0}}};
    assign d_dvd2[0]   = {r_p_mag2, {FRAC_BITS{1'b0}}};
    assign d_rem1[0]   = '0;
    assign d_rem2[0]   = '0;
    assign d_q1[0]     = '0;
    assign d_q2[0]     = '0;

    for (genvar j = 0; j < DV_W; j++) begin : g_div
        logic             r_v;
        logic [1:0]       r_status;
        logic [DEN_W-1:0] r_den;
        logic             r_neg1;
        logic             r_neg2;
        logic [DV_W-1:0]  r_dvd1;
        logic [DV_W-1:0]  r_dvd2;
        logic [DEN_W-1:0] r_rem1;
        logic [DEN_W-1:0] r_rem2;
        logic [DV_W-1:0]  r_q1;
        logic [DV_W-1:0]  r_q2;
        logic [DEN_W:0]   w_cur1;
        logic [DEN_W:0]   w_cur2;
        logic [DEN_W:0]   w_sub1;
        logic [DEN_W:0]   w_sub2;
        logic             w_ge1;
        logic             w_ge2;

        always_comb begin
            w_cur1 = {d_rem1[j], d_dvd1[j][DV_W-1-j]};
            w_cur2 = {d_rem2[j], d_dvd2[j][DV_W-1-j]};
            w_ge1  = (w_cur1 >= {1'b0, d_den[j]});
            w_ge2  = (w_cur2 >= {1'b0, d_den[j]});
            w_sub1 = w_cur1 - {1'b0, d_den[j]};
            w_sub2 = w_cur2 - {1'b0, d_den[j]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_en) begin
                r_v <= d_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_status <= d_status[j];
                r_den    <= d_den[j];
                r_neg1   <= d_neg1[j];
                r_neg2   <= d_neg2[j];
                r_dvd1   <= d_dvd1[j];
                r_dvd2   <= d_dvd2[j];
                r_rem1   <= w_ge1 ? w_sub1[DEN_W-1:0] : w_cur1[DEN_W-1:0];
                r_rem2   <= w_ge2 ? w_sub2[DEN_W-1:0] : w_cur2[DEN_W-1:0];
                r_q1     <= {d_q1[j][DV_W-2:0], w_ge1};
                r_q2     <= {d_q2[j][DV_W-2:0], w_ge2};
            end
        end

        assign d_v[j+1]      = r_v;
        assign d_status[j+1] = r_status;
        assign d_den[j+1]    = r_den;
        assign d_neg1[j+1]   = r_neg1;
        assign d_neg2[j+1]   = r_neg2;
        assign d_dvd1[j+1]   = r_dvd1;
        assign d_dvd2[j+1]   = r_dvd2;
        assign d_rem1[j+1]   = r_rem1;
        assign d_rem2[j+1]   = r_rem2;
        assign d_q1[j+1]     = r_q1;
        assign d_q2[j+1]     = r_q2;
    end

    // Saturation and output register.
    localparam logic [DV_W-1:0] LIM_POS = DV_W'((64'd1 << (COEF_W - 1)) - 64'd1);
    localparam logic [DV_W-1:0] LIM_NEG = DV_W'(64'd1 << (COEF_W - 1));

    logic              r_out_valid;
    t_root_out         r_out;
    t_root_out         n_out;
    logic [DV_W-1:0]   w_lim1;
    logic [DV_W-1:0]   w_lim2;
    logic              w_ovf1;
    logic              w_ovf2;
    logic [COEF_W-1:0] w_m1;
    logic [COEF_W-1:0] w_m2;

    always_comb begin
        w_lim1 = d_neg1[DV_W] ? LIM_NEG : LIM_POS;
        w_lim2 = d_neg2[DV_W] ? LIM_NEG : LIM_POS;
        w_ovf1 = (d_q1[DV_W] > w_lim1);
        w_ovf2 = (d_q2[DV_W] > w_lim2);
        w_m1   = w_ovf1 ? w_lim1[COEF_W-1:0] : d_q1[DV_W][COEF_W-1:0];
        w_m2   = w_ovf2 ? w_lim2[COEF_W-1:0] : d_q2[DV_W][COEF_W-1:0];

        n_out              = '0;
        n_out.solve_status = d_status[DV_W];
        case (d_status[DV_W])
            ST_TWO: begin
                n_out.root_one = d_neg1[DV_W] ? -w_m1 : w_m1;
                n_out.root_two = d_neg2[DV_W] ? -w_m2 : w_m2;
                n_out.overflow = w_ovf1 || w_ovf2;
            end
            ST_DOUBLE, ST_LINEAR: begin
                n_out.root_one = d_neg1[DV_W] ? -w_m1 : w_m1;
                n_out.overflow = w_ovf1;
            end
            default: begin
                n_out.solve_status = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= d_v[DV_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_root  = r_out;

endmodule

>>> rtl/core/quadratic_root_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver
// Solves a*x^2 + b*x + c = 0 for signed fixed-point coefficients.
// ----------------------------------------------------------------------------
// The block takes one coefficient word per cycle and returns one result word
// per cycle in order, unless the output is stalled. A word passes through two
// front registers for the products and discriminant, the queue, one square root
// stage per root bit, one numerator stage, one divider stage per quotient bit
// and the output register.
// The threshold may be written only while no word is in flight.
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_coef_in         i_coef,
    output logic             o_valid,
    input  logic             i_ready,
    output t_root_out        o_root,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata
);

    logic [THR_W-1:0] r_threshold;
    logic             w_fq_valid;
    logic             w_fq_ready;
    t_job             w_fq_job;
    logic             w_qb_valid;
    logic             w_qb_ready;
    t_job             w_qb_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    qrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_coef      (i_coef),
        .i_threshold (r_threshold),
        .o_job_valid (w_fq_valid),
        .i_job_ready (w_fq_ready),
        .o_job       (w_fq_job)
    );

    qrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_job   (w_fq_job),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_job    (w_qb_job)
    );

    qrs_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qb_valid),
        .o_job_ready (w_qb_ready),
        .i_job       (w_qb_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_root      (o_root)
    );

`ifndef SYNTHESIS
    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root.solve_status == ST_NONE) |->
        (o_root.root_one == '0 && o_root.root_two == '0 && !o_root.overflow))
        else $error("no-solution word carries a nonzero field");

    a_single_root_two_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root.solve_status != ST_TWO) |-> (o_root.root_two == '0))
        else $error("second root set on a single-root word");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives coefficient words through a valid/ready channel with random idling,
// predicts each root word with an exact integer model of the solver and
// compares every field of the returned words in order.
// ----------------------------------------------------------------------------
module tb;
    import qrs_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    t_coef_in         i_coef;
    logic             o_valid;
    logic             i_ready;
    t_root_out        o_root;
    logic             i_cfg_we;
    logic [THR_W-1:0] i_cfg_wdata;

    quadratic_root_solver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_coef      (i_coef),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_root      (o_root),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    t_coef_in    pending_coefs[$];
    t_root_out   expected_roots[$];
    logic [31:0] threshold;
    int          error_count;
    bit          calm;
    bit          hold_send;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Truncating quotient of (mag << FRAC_BITS) / den with sign and saturation.
    function automatic logic [31:0] scaled_quot(input logic [127:0] mag,
                                                input logic [127:0] den,
                                                input bit neg, inout bit ovf);
        logic [127:0] q;
        logic [127:0] lim;
        q   = (mag << 16) / den;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
            q   = lim;
            ovf = 1'b1;
        end
        return neg ? 32'(-q) : 32'(q);
    endfunction

    function automatic logic [127:0] int_sqrt(input logic [127:0] n);
        logic [127:0] r;
        logic [127:0] b;
        logic [127:0] t;
        r = 0;
        b = 128'd1 << 126;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            t = r + b;
            if (n >= t) begin
                n = n - t;
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_root_out solve_roots(input t_coef_in c);
        t_root_out       res;
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] k;
        logic signed [127:0] d;
        logic signed [127:0] s;
        logic signed [127:0] num;
        logic [127:0]    den;
        bit              ovf;
        a   = c.coef_a;
        b   = c.coef_b;
        k   = c.coef_c;
        ovf = 1'b0;
        res = '0;
        res.solve_status = ST_NONE;
        if (a != 0) begin
            d   = b * b - 4 * a * k;
            den = (a < 0) ? -a : a;
            den = den << 1;
            if (d >= 0) begin
                if (d >= $signed({96'd0, threshold})) begin
                    s   = int_sqrt(d);
                    num = -b + s;
                    res.root_one = scaled_quot(num < 0 ? -num : num, den,
                                               (num < 0) != (a < 0), ovf);
                    num = -b - s;
                    res.root_two = scaled_quot(num < 0 ? -num : num, den,
                                               (num < 0) != (a < 0), ovf);
                    res.solve_status = ST_TWO;
                end else begin
                    num = -b;
                    res.root_one = scaled_quot(num < 0 ? -num : num, den,
                                               (num < 0) != (a < 0), ovf);
                    res.solve_status = ST_DOUBLE;
                end
            end
        end else if (b != 0) begin
            num = -k;
            res.root_one = scaled_quot(num < 0 ? -num : num, b < 0 ? -b : b,
                                       (num < 0) != (b < 0), ovf);
            res.solve_status = ST_LINEAR;
        end
        res.overflow = ovf;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 131072)) - 65536);
            1: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
            2: return 32'($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff);
            3: return 32'($urandom_range(0, 1) ? 0 : 32'h0001_0000);
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_word(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c);
        t_coef_in w;
        w.coef_a = a;
        w.coef_b = b;
        w.coef_c = c;
        pending_coefs.push_back(w);
    endtask

    task automatic drain_and_wait();
        while (pending_coefs.size() != 0 || expected_roots.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        threshold   <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) expected_roots.push_back(solve_roots(i_coef));
            if (pending_coefs.size() != 0 && !hold_send
                && (calm || $urandom_range(0, 99) >= 14)) begin
                i_valid <= 1'b1;
                i_coef  <= pending_coefs.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_root_out want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_roots.size() == 0) begin
                    report_mismatch("unexpected word", o_root.root_one, '0);
                end else begin
                    want = expected_roots.pop_front();
                    if (o_root.root_one !== want.root_one)
                        report_mismatch("root_one", o_root.root_one, want.root_one);
                    if (o_root.root_two !== want.root_two)
                        report_mismatch("root_two", o_root.root_two, want.root_two);
                    if (o_root.solve_status !== want.solve_status)
                        report_mismatch("solve_status", 32'(o_root.solve_status),
                                        32'(want.solve_status));
                    if (o_root.overflow !== want.overflow)
                        report_mismatch("overflow", 32'(o_root.overflow),
                                        32'(want.overflow));
                end
            end
            i_ready <= calm || ($urandom_range(0, 99) >= 14);
        end
    end

    initial begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [31:0] thr_list [4];
        error_count = 0;
        calm        = 1'b0;
        hold_send   = 1'b0;
        threshold   = '0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_coef      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        thr_list    = '{32'hffff_ffff, 32'h0001_0000, 32'd1, 32'd0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_threshold(32'd0);

        queue_word(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
        queue_word(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
        queue_word(32'h0001_0000, 32'h0, 32'h0001_0000);
        queue_word(32'h0, 32'h0002_0000, 32'hfffc_0000);
        queue_word(32'h0, 32'h0, 32'h0001_0000);
        queue_word(32'h0, 32'h0, 32'h0);
        queue_word(32'h0, 32'h1, 32'h7fff_ffff);
        queue_word(32'h0, 32'hffff_ffff, 32'h8000_0000);
        queue_word(32'h1, 32'h7fff_ffff, 32'h0);
        queue_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_word(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_word(32'hffff_ffff, 32'h0, 32'h1);
        queue_word(32'h1, 32'h2, 32'h1);
        queue_word(32'h1, 32'h0, 32'h0);
        queue_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        drain_and_wait();

        for (int p = 0; p < 4; p++) begin
            write_threshold(p == 3 ? $urandom() : thr_list[p]);
            queue_word(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
            queue_word(32'h0001_0000, 32'hfffe_0000, 32'h0000_ffff);
            queue_word(32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000);
            calm = (p == 1);
            for (int n = 0; n < 400; n++) queue_word(rand_coef(), rand_coef(), rand_coef());
            if (p == 2) begin
                while (pending_coefs.size() > 200) @(posedge i_clk);
                hold_send = 1'b1;
                while (expected_roots.size() != 0 || i_valid)
                    @(posedge i_clk);
                hold_send = 1'b0;
            end
            drain_and_wait();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_queue.sv
rtl/core/qrs_back.sv
rtl/core/quadratic_root_solver.sv
test/tb.sv
